/* design/pbs_pkg.sv */
// Shared types and defaults for the preamble / bit-stuffing serializer.
package pbs_pkg;

  localparam int PREAMBLE_PAIRS_DEFAULT = 8;
  localparam int CHAR_BITS_DEFAULT      = 8;
  localparam int CHAR_W                 = 8;

  // req_type codes
  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] char_value;
  } req_item_t;

  typedef struct packed {
    logic coded_bit;
    logic stuffed;
    logic last_of_run;
  } res_item_t;

endpackage

/* design/pbs_expand.sv */
// Expands one item into its full run of channel bits, first bit at index 0.
module pbs_expand import pbs_pkg::*; #(
  parameter int PREAMBLE_PAIRS = PREAMBLE_PAIRS_DEFAULT,
  parameter int CHAR_BITS      = CHAR_BITS_DEFAULT,
  // longest character run is CHAR_BITS data bits plus one pair per zero after a one
  parameter int MAX_BITS       = ((CHAR_BITS + 2 * ((CHAR_BITS + 1) / 2)) > 2 * PREAMBLE_PAIRS)
                                 ? (CHAR_BITS + 2 * ((CHAR_BITS + 1) / 2))
                                 : 2 * PREAMBLE_PAIRS,
  parameter int CNT_W          = $clog2(MAX_BITS + 1),
  parameter int IDX_W          = $clog2(MAX_BITS)
) (
  input  req_item_t           item,
  input  logic                last_one,
  output logic [MAX_BITS-1:0] bits,
  output logic [MAX_BITS-1:0] stf,
  output logic [CNT_W-1:0]    count,
  output logic                last_one_next
);

  always_comb begin
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] pos1;
    logic             prev;
    logic             b;
    bits          = '0;
    stf           = '0;
    pos           = '0;
    pos1          = '0;
    prev          = last_one;
    b             = 1'b0;
    last_one_next = last_one;
    if (item.req_type == REQ_START) begin
      for (int p = 0; p < PREAMBLE_PAIRS; p++) begin
        bits[2*p]   = 1'b1;
        stf[2*p]    = 1'b1;
        bits[2*p+1] = 1'b0;
        stf[2*p+1]  = 1'b1;
      end
      count = CNT_W'(2 * PREAMBLE_PAIRS);
    end else begin
      // MSB first; a 1-to-0 transition gets a stuffed 1,0 pair in front
      for (int i = CHAR_BITS - 1; i >= 0; i--) begin
        b = item.char_value[i];
        if (prev && !b) begin
          pos1               = pos + CNT_W'(1);
          bits[pos[IDX_W-1:0]]  = 1'b1;
          stf[pos[IDX_W-1:0]]   = 1'b1;
          bits[pos1[IDX_W-1:0]] = 1'b0;
          stf[pos1[IDX_W-1:0]]  = 1'b1;
          pos                = pos + CNT_W'(2);
        end
        bits[pos[IDX_W-1:0]] = b;
        stf[pos[IDX_W-1:0]]  = 1'b0;
        pos                  = pos + CNT_W'(1);
        prev                 = b;
      end
      count         = pos;
      last_one_next = prev;
    end
  end

endmodule

/* design/preamble_stuffing_bit_serializer_top.sv */
// Top level of the preamble / bit-stuffing serializer.
// Each request item turns into a run of channel bits, one result item per bit, one bit per
// cycle while res_ready is high. A start item gives 2*PREAMBLE_PAIRS preamble bits (1,0
// pairs, all marked stuffed); a character item gives its low CHAR_BITS bits MSB first, with
// a stuffed 1,0 pair in front of every data 0 that follows a data 1, so a character gives
// CHAR_BITS bits plus two per stuffed pair (8 to 16 at the defaults; at most
// 2*CHAR_BITS+1 for an odd CHAR_BITS) and a start item 2*PREAMBLE_PAIRS (16). The
// output shift register sets the bit rate: the next item waits in a holding register, is
// expanded in one pass and loaded in the cycle the last bit of the current run leaves, so
// runs follow each other with no gap. last_of_run flags the final bit of each run. The
// remembered last data bit survives across characters and messages; the preamble leaves it
// alone. Reset clears it to 0.
module preamble_stuffing_bit_serializer_top import pbs_pkg::*; #(
  parameter int PREAMBLE_PAIRS = PREAMBLE_PAIRS_DEFAULT,
  parameter int CHAR_BITS      = CHAR_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  // longest character run: every data 0 preceded by a 1, including the remembered bit
  localparam int CHAR_MAX_BITS = CHAR_BITS + 2 * ((CHAR_BITS + 1) / 2);
  localparam int MAX_BITS = (CHAR_MAX_BITS > 2 * PREAMBLE_PAIRS) ? CHAR_MAX_BITS
                                                                 : 2 * PREAMBLE_PAIRS;
  localparam int CNT_W    = $clog2(MAX_BITS + 1);
  localparam int IDX_W    = $clog2(MAX_BITS);

  // holding register for the next item
  logic      hold_valid;
  req_item_t hold;

  // output shift register: bit 0 is on the port
  logic [MAX_BITS-1:0] bits_q;
  logic [MAX_BITS-1:0] stf_q;
  logic [CNT_W-1:0]    cnt;
  logic                last_one;

  logic [MAX_BITS-1:0] exp_bits;
  logic [MAX_BITS-1:0] exp_stf;
  logic [CNT_W-1:0]    exp_count;
  logic                exp_last_one;

  logic res_fire;
  logic req_fire;
  logic load;

  pbs_expand #(
    .PREAMBLE_PAIRS (PREAMBLE_PAIRS),
    .CHAR_BITS      (CHAR_BITS),
    .MAX_BITS       (MAX_BITS),
    .CNT_W          (CNT_W),
    .IDX_W          (IDX_W)
  ) u_expand (
    .item          (hold),
    .last_one      (last_one),
    .bits          (exp_bits),
    .stf           (exp_stf),
    .count         (exp_count),
    .last_one_next (exp_last_one)
  );

  assign res_valid       = (cnt != '0);
  assign res.coded_bit   = bits_q[0];
  assign res.stuffed     = stf_q[0];
  assign res.last_of_run = (cnt == CNT_W'(1));

  assign res_fire  = res_valid && res_ready;
  // shifter is free now, or frees up as its final bit leaves
  assign load      = hold_valid && ((cnt == '0) || (res_fire && res.last_of_run));
  assign req_ready = !hold_valid || load;
  assign req_fire  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_fire) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      hold <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      last_one <= 1'b0;
    end else if (load) begin
      cnt      <= exp_count;
      last_one <= exp_last_one;
    end else if (res_fire) begin
      cnt      <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bits_q <= exp_bits;
      stf_q  <= exp_stf;
    end else if (res_fire) begin
      bits_q <= bits_q >> 1;
      stf_q  <= stf_q >> 1;
    end
  end

  // a stuffed 1 is always followed by its stuffed 0 in the same run
  a_pair_complete: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.stuffed && res.coded_bit) |=> (res_valid && res.stuffed && !res.coded_bit))
    else $error("stuffed pair broken");

  // the shifter is reloaded only when empty or on the final bit of a run
  a_load_at_end: assert property (@(posedge clk) disable iff (rst)
    load |-> ((cnt == '0) || (res_fire && res.last_of_run)))
    else $error("shifter reloaded mid-run");

  // a waiting item is held until it moves into the shifter
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !load) |=> (hold_valid && $stable(hold)))
    else $error("held item lost or changed");

endmodule

/* bench/tb_preamble_stuffing_bit_serializer_top.sv */
// Self-checking testbench for the preamble / bit-stuffing serializer top level.
module tb_preamble_stuffing_bit_serializer_top;
  import pbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAIRS        = PREAMBLE_PAIRS_DEFAULT;
  localparam int CBITS        = CHAR_BITS_DEFAULT;
  localparam int DIR_ROWS     = 18;
  localparam int RAND_ITEMS   = 300;
  localparam int CALM_FROM    = 110;  // random items in (CALM_FROM, CALM_TO] see no idling
  localparam int CALM_TO      = 180;
  localparam int PAUSE_AT     = 220;  // sender waits for every pending bit here
  localparam int HOLD_AT      = 1200; // receiver backs off after this many bits
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 2000; // cycles without any handshake before giving up

  // Directed row: the item, plus an optional typed-in run (typed_len == 0 means
  // the predictor alone supplies the expectation). Patterns are MSB first.
  typedef struct packed {
    req_item_t   item;
    logic [4:0]  typed_len;
    logic [15:0] typed_coded;
    logic [15:0] typed_stf;
  } dir_row_t;

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req       = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_item_t res;

  logic        calm = 1'b0;    // no idling on either side while set
  res_item_t   pending_bits [$];
  int unsigned bits_seen  = 0;
  int unsigned mismatches = 0;
  logic        prev_data_one = 1'b0; // predictor copy of the remembered data bit

  // Rows 0-5 walk the state on purpose: all zeros from reset, a full preamble,
  // all ones (leaves a 1 behind), a preamble that must not disturb that 1, a zero
  // character right after it (one stuffed pair), and 0xAA for the 16-bit worst case.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{REQ_CHAR,  8'h00}, 5'd8,  16'h0000, 16'h0000},
    '{'{REQ_START, 8'hAB}, 5'd16, 16'hAAAA, 16'hFFFF},
    '{'{REQ_CHAR,  8'hFF}, 5'd8,  16'h00FF, 16'h0000},
    '{'{REQ_START, 8'h00}, 5'd16, 16'hAAAA, 16'hFFFF},
    '{'{REQ_CHAR,  8'h00}, 5'd10, 16'h0200, 16'h0300},
    '{'{REQ_CHAR,  8'hAA}, 5'd16, 16'hCCCC, 16'h6666},
    '{'{REQ_CHAR,  8'h55}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_CHAR,  8'h80}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_CHAR,  8'h01}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_CHAR,  8'h7F}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_CHAR,  8'hFE}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_START, 8'hFF}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_CHAR,  8'h0F}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_CHAR,  8'hF0}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_START, 8'h55}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_CHAR,  8'h00}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_CHAR,  8'hFF}, 5'd0,  16'h0000, 16'h0000},
    '{'{REQ_CHAR,  8'h81}, 5'd0,  16'h0000, 16'h0000}
  };

  preamble_stuffing_bit_serializer_top #(
    .PREAMBLE_PAIRS(PAIRS),
    .CHAR_BITS     (CBITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expand one accepted item into its channel bits and queue them. The
  // predictor always runs so the remembered data bit stays in step; a typed-in
  // run from the directed table then replaces its output.
  task automatic serialize_item(input req_item_t it, input logic [4:0] tlen,
                                input logic [15:0] tcoded, input logic [15:0] tstf);
    res_item_t run [$];
    res_item_t r;
    logic      b;
    if (it.req_type == REQ_START) begin
      // preamble: 1,0 pairs, all flagged; data-bit memory untouched
      for (int p = 0; p < PAIRS; p++) begin
        run.push_back('{1'b1, 1'b1, 1'b0});
        run.push_back('{1'b0, 1'b1, 1'b0});
      end
    end else begin
      // low CBITS bits MSB first; a 0 after a data 1 gets a stuffed 1,0 pair
      for (int i = CBITS - 1; i >= 0; i--) begin
        b = it.char_value[i];
        if (prev_data_one && !b) begin
          run.push_back('{1'b1, 1'b1, 1'b0});
          run.push_back('{1'b0, 1'b1, 1'b0});
        end
        run.push_back('{b, 1'b0, 1'b0});
        prev_data_one = b;
      end
    end
    if (tlen != 0) begin
      run = {};
      for (int k = int'(tlen) - 1; k >= 0; k--)
        run.push_back('{tcoded[k], tstf[k], 1'b0});
    end
    for (int k = 0; k < run.size(); k++) begin
      r = run[k];
      r.last_of_run = (k == run.size() - 1);
      pending_bits.push_back(r);
    end
  endtask

  // Present one item, idling at random first unless calm. Valid is only
  // lowered when an idle gap follows, so it is never dropped and re-raised
  // in the same step.
  task automatic offer(input req_item_t it, input logic [4:0] tlen,
                       input logic [15:0] tcoded, input logic [15:0] tstf);
    if (!calm && $urandom_range(99) < 38) begin
      req_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 38);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (!(req_valid && req_ready));
    // accepted at this edge; its first bit can only show up at a later one
    serialize_item(it, tlen, tcoded, tstf);
  endtask

  // Sender stops and waits until every queued bit has been delivered.
  task automatic drain_pending();
    req_valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
    end
  endfunction

  // Result side: every accepted bit is matched against the oldest pending one.
  always @(posedge clk) begin : check_bits
    res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_bits.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected bit, expected none actual coded=%b stuffed=%b last=%b",
                 $time, res.coded_bit, res.stuffed, res.last_of_run);
      end else begin
        want = pending_bits.pop_front();
        check_field("coded_bit",   want.coded_bit,   res.coded_bit);
        check_field("stuffed",     want.stuffed,     res.stuffed);
        check_field("last_of_run", want.last_of_run, res.last_of_run);
      end
      bits_seen <= bits_seen + 1;
    end
  end

  // Receiver: random backpressure, none while calm, and one long hold-off
  // that lets the block fill up and stall its input.
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && bits_seen >= HOLD_AT) begin
        held_off = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ready <= calm || ($urandom_range(99) >= 38);
      @(posedge clk);
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (res_valid && res_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("preamble_stuffing_bit_serializer_top verification failed");
    $finish;
  end

  // Stimulus: directed table, a full drain, then random messages.
  initial begin : stimulus
    req_item_t it;
    int        n;
    int        chars_left;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r])
      offer(dir_rows[r].item, dir_rows[r].typed_len, dir_rows[r].typed_coded,
            dir_rows[r].typed_stf);
    drain_pending();

    // Random part: mostly messages (a start item, then 1..12 characters),
    // with some stray characters outside any message. Character values lean
    // toward the patterns that stress stuffing.
    n = 0;
    chars_left = 0;
    while (n < RAND_ITEMS) begin
      if (n == CALM_FROM) calm <= 1'b1;
      if (n == CALM_TO)   calm <= 1'b0;
      if (n == PAUSE_AT)  drain_pending();
      if (chars_left == 0 && $urandom_range(99) < 85) begin
        it.req_type = REQ_START;
        chars_left  = $urandom_range(12, 1);
      end else begin
        it.req_type = REQ_CHAR;
        if (chars_left != 0) chars_left--;
      end
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(5))
          0:       it.char_value = 8'h00;
          1:       it.char_value = 8'hFF;
          2:       it.char_value = 8'hAA;
          3:       it.char_value = 8'h55;
          4:       it.char_value = 8'h80;
          default: it.char_value = 8'h01;
        endcase
      end else begin
        it.char_value = CHAR_W'($urandom_range(255));
      end
      offer(it, 5'd0, 16'h0000, 16'h0000);
      n++;
    end

    drain_pending();
    // a few more cycles so any stray extra bit is caught
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("preamble_stuffing_bit_serializer_top verification clean");
    else
      $display("preamble_stuffing_bit_serializer_top verification failed");
    $finish;
  end

endmodule
